// ===== hw/rtl/mbe_pkg.sv =====
// Package for the escape-time pixel engine: shared types, codes and
// saturating fixed-point helpers. No dependencies.
package mbe_pkg;

   typedef logic signed [63:0] fix_type;

   typedef struct packed {
      fix_type c_re;
      fix_type c_im;
   } coord_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_XY,
      ST_ADD,
      ST_MUL_XX,
      ST_MUL_YY,
      ST_CHECK,
      ST_DONE
   } back_state_type;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_CENTER_RE    = 3'd2,
      REG_CENTER_IM    = 3'd3,
      REG_SEED_RE      = 3'd4,
      REG_SEED_IM      = 3'd5,
      REG_PIXEL_STEP   = 3'd6,
      REG_MAX_ITER     = 3'd7
   } csr_index_type;

   localparam int unsigned BAILOUT_INT  = 400;
   localparam int unsigned CYCLE_PERIOD = 25;
   localparam int unsigned PC_WIDTH     = 5;

   localparam fix_type FIX_MAX = {1'b0, {63{1'b1}}};
   localparam fix_type FIX_MIN = {1'b1, {63{1'b0}}};

   function automatic fix_type sat_wide(logic signed [64:0] s);
      fix_type r;
      if (s[64] != s[63]) begin
         r = s[64] ? FIX_MIN : FIX_MAX;
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

   function automatic fix_type sat_add(fix_type a, fix_type b);
      return sat_wide({a[63], a} + {b[63], b});
   endfunction

   function automatic fix_type sat_sub(fix_type a, fix_type b);
      return sat_wide({a[63], a} - {b[63], b});
   endfunction

   // sign a magnitude; big flags bits above bit 63
   function automatic fix_type sign_sat(logic neg, logic big, logic [63:0] mag);
      fix_type r;
      if (neg) begin
         r = (big || mag[63]) ? FIX_MIN : fix_type'(-mag);
      end else begin
         r = (big || mag[63]) ? FIX_MAX : fix_type'(mag);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mbe_queue.sv =====
// Two-entry queue of pixel coordinates between front and back.
// Depends on mbe_pkg.
module mbe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  mbe_pkg::coord_type push_data,
   output logic              has_room,
   input  logic              pop,
   output logic              not_empty,
   output mbe_pkg::coord_type head
);
   import mbe_pkg::*;

   coord_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign has_room  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && has_room;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/mbe_front.sv =====
// Front end: takes a pixel beat and forms c = center + (index - size/2) * step.
// Depends on mbe_pkg.
module mbe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [11:0]        req_column,
   input  logic [11:0]        req_row,
   input  logic [12:0]        image_width,
   input  logic [12:0]        image_height,
   input  mbe_pkg::fix_type   center_re,
   input  mbe_pkg::fix_type   center_im,
   input  logic [62:0]        pixel_step,
   input  logic               q_has_room,
   output logic               push_valid,
   output mbe_pkg::coord_type push_data
);
   import mbe_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   logic               s2_valid_ff, s2_valid_in;
   logic signed [12:0] d_col_ff, d_row_ff;
   logic [12:0]        abs_col, abs_row;
   logic [74:0]        prod_col_ff, prod_row_ff;
   logic               neg_col_ff, neg_row_ff;
   logic               take;

   assign req_ready = !s1_valid_ff && !s2_valid_ff && q_has_room;
   assign take      = req_valid && req_ready;

   assign abs_col = d_col_ff[12] ? 13'(-d_col_ff) : 13'(d_col_ff);
   assign abs_row = d_row_ff[12] ? 13'(-d_row_ff) : 13'(d_row_ff);

   always_comb begin
      s1_valid_in = take;
      s2_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         d_col_ff <= $signed({1'b0, req_column}) - $signed({1'b0, image_width[12:1]});
         d_row_ff <= $signed({1'b0, req_row}) - $signed({1'b0, image_height[12:1]});
      end
      if (s1_valid_ff) begin
         prod_col_ff <= 75'(abs_col[11:0]) * 75'(pixel_step);
         prod_row_ff <= 75'(abs_row[11:0]) * 75'(pixel_step);
         neg_col_ff  <= d_col_ff[12];
         neg_row_ff  <= d_row_ff[12];
      end
   end

   assign push_valid = s2_valid_ff;
   always_comb begin
      push_data.c_re = sat_add(center_re,
         sign_sat(neg_col_ff, |prod_col_ff[74:64], prod_col_ff[63:0]));
      push_data.c_im = sat_add(center_im,
         sign_sat(neg_row_ff, |prod_row_ff[74:64], prod_row_ff[63:0]));
   end

endmodule

// ===== hw/rtl/mbe_mul.sv =====
// Sequential signed fixed-point multiplier: four 32x32 partial products,
// then shift by FRAC_BITS with saturation. Depends on mbe_pkg.
module mbe_mul #(
   parameter int FRAC_BITS = 52
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mbe_pkg::fix_type op_a,
   input  mbe_pkg::fix_type op_b,
   output logic             busy,
   output logic             done,
   output mbe_pkg::fix_type result
);
   import mbe_pkg::*;

   logic         busy_ff;
   logic [2:0]   cnt_ff;
   logic [63:0]  mag_a_ff, mag_b_ff;
   logic         neg_ff;
   logic [63:0]  prod_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic [31:0]  part_a, part_b;
   logic [127:0] scaled;

   assign busy   = busy_ff;
   assign done   = busy_ff && (cnt_ff == 3'd5);
   assign part_a = cnt_ff[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
   assign part_b = cnt_ff[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];
   assign scaled = acc_ff >> FRAC_BITS;
   assign result = sign_sat(neg_ff, |scaled[127:64], scaled[63:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 3'd0;
      end else if (busy_ff) begin
         busy_ff <= !done;
         cnt_ff  <= cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mag_a_ff <= op_a[63] ? 64'(-op_a) : 64'(op_a);
         mag_b_ff <= op_b[63] ? 64'(-op_b) : 64'(op_b);
         neg_ff   <= op_a[63] ^ op_b[63];
         acc_ff   <= '0;
      end else if (busy_ff) begin
         if (cnt_ff < 3'd4) begin
            prod_ff <= 64'(part_a) * 64'(part_b);
            sh_ff   <= 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
         end
         if (cnt_ff != 3'd0 && cnt_ff <= 3'd4) begin
            acc_ff <= acc_ff + (128'(prod_ff) << {sh_ff, 5'b0});
         end
      end
   end

endmodule

// ===== hw/rtl/mbe_back.sv =====
// Back end: escape-time iteration sequencer around one shared multiplier,
// with the result register. Depends on mbe_pkg and mbe_mul.
module mbe_back #(
   parameter int FRAC_BITS  = 52,
   parameter int ITER_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  mbe_pkg::fix_type   seed_re,
   input  mbe_pkg::fix_type   seed_im,
   input  logic [15:0]        max_iterations,
   input  logic               q_not_empty,
   input  mbe_pkg::coord_type q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_iterations,
   output logic               rsp_inside_res,
   output logic [62:0]        rsp_magnitude_sq
);
   import mbe_pkg::*;

   localparam logic [64:0] BAIL_LIMIT = 65'(BAILOUT_INT) << FRAC_BITS;
   localparam logic [31:0] ITER_MAX   = 32'((33'd1 << ITER_WIDTH) - 33'd1);

   back_state_type state_ff, state_in;
   fix_type x_ff, y_ff, x2_ff, y2_ff, px_ff, py_ff, cx_ff, cy_ff;
   logic [63:0]           sum_ff, sum_in;
   logic [ITER_WIDTH-1:0] i_ff, i_in, limit_ff, limit_in, i_inc;
   logic [PC_WIDTH-1:0]   pc_ff, pc_inc;
   logic [31:0]           lim_raw;
   logic                  over, wrap, match, keep_going, start_ok;
   logic                  mul_start, mul_busy, mul_done, load_out;
   fix_type               mul_a, mul_b, mul_res;
   logic                  rsp_valid_ff;
   logic [15:0]           rsp_iter_ff;
   logic                  rsp_inside_ff;
   logic [62:0]           rsp_mag_ff;

   mbe_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .busy   (mul_busy),
      .done   (mul_done),
      .result (mul_res)
   );

   // limit: zero acts as one, clamp to counter range
   always_comb begin
      lim_raw  = (max_iterations == 16'd0) ? 32'd1 : 32'(max_iterations);
      lim_raw  = (lim_raw > ITER_MAX) ? ITER_MAX : lim_raw;
      limit_in = lim_raw[ITER_WIDTH-1:0];
      start_ok = limit_in > ITER_WIDTH'(1);
   end

   // end-of-iteration checks
   always_comb begin
      sum_in     = 64'(x2_ff) + 64'(y2_ff);
      over       = (x2_ff == FIX_MAX) || (y2_ff == FIX_MAX) || ({1'b0, sum_in} > BAIL_LIMIT);
      i_inc      = i_ff + ITER_WIDTH'(1);
      pc_inc     = pc_ff + PC_WIDTH'(1);
      wrap       = 32'(pc_inc) >= CYCLE_PERIOD;
      match      = (px_ff == x_ff) && (py_ff == y_ff);
      i_in       = (wrap && match) ? limit_ff : i_inc;
      keep_going = (i_in < limit_ff) && !over;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (q_not_empty) state_in = start_ok ? ST_MUL_XY : ST_DONE;
         ST_MUL_XY: if (mul_done) state_in = ST_ADD;
         ST_ADD:    state_in = ST_MUL_XX;
         ST_MUL_XX: if (mul_done) state_in = ST_MUL_YY;
         ST_MUL_YY: if (mul_done) state_in = ST_CHECK;
         ST_CHECK:  state_in = keep_going ? ST_MUL_XY : ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      mul_start = 1'b0;
      load_out  = 1'b0;
      mul_a     = x_ff;
      mul_b     = y_ff;
      unique case (state_ff)
         ST_IDLE:   q_pop = q_not_empty;
         ST_MUL_XY: mul_start = !mul_busy;
         ST_MUL_XX: begin
            mul_start = !mul_busy;
            mul_b     = x_ff;
         end
         ST_MUL_YY: begin
            mul_start = !mul_busy;
            mul_a     = y_ff;
         end
         ST_DONE:   load_out = !rsp_valid_ff || rsp_ready;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               cx_ff    <= q_head.c_re;
               cy_ff    <= q_head.c_im;
               x_ff     <= seed_re;
               y_ff     <= seed_im;
               px_ff    <= seed_re;
               py_ff    <= seed_im;
               x2_ff    <= '0;
               y2_ff    <= '0;
               sum_ff   <= '0;
               i_ff     <= ITER_WIDTH'(1);
               pc_ff    <= PC_WIDTH'(1);
               limit_ff <= limit_in;
            end
         end
         ST_MUL_XY: if (mul_done) y_ff <= mul_res;
         ST_ADD: begin
            // y_ff holds xy here
            y_ff <= sat_add(sat_add(y_ff, y_ff), cy_ff);
            x_ff <= sat_add(sat_sub(x2_ff, y2_ff), cx_ff);
         end
         ST_MUL_XX: if (mul_done) x2_ff <= mul_res;
         ST_MUL_YY: if (mul_done) y2_ff <= mul_res;
         ST_CHECK: begin
            sum_ff <= sum_in;
            i_ff   <= i_in;
            pc_ff  <= wrap ? '0 : pc_inc;
            if (wrap && !match) begin
               px_ff <= x_ff;
               py_ff <= y_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_iter_ff   <= 16'(32'(i_ff));
         rsp_inside_ff <= (i_ff == limit_ff);
         rsp_mag_ff    <= sum_ff[63] ? {63{1'b1}} : sum_ff[62:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_iterations   = rsp_iter_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_magnitude_sq = rsp_mag_ff;

   a_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_XY || state_ff == ST_MUL_XX || state_ff == ST_MUL_YY))
      else $error("multiplier finished outside a multiply state");
   a_iter_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (i_ff <= limit_ff))
      else $error("iteration count above limit");
   a_phase_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (32'(pc_ff) < CYCLE_PERIOD))
      else $error("period phase out of range");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiply issued while busy");

endmodule

// ===== hw/rtl/mandelbrot_escape_iteration.sv =====
// Top level of the escape-time pixel engine: configuration registers, front end,
// coordinate queue and iteration back end. Depends on mbe_pkg and all mbe_ modules.
//
// Usage:
//  - req_ channel: one beat per pixel (column, row). Accepted on req_valid && req_ready.
//  - rsp_ channel: one beat per pixel (iterations, inside_res, magnitude_sq), in order.
//  - csr_ channel: register index and 64-bit data, always ready; write only when idle.
//  - The front forms the pixel's c in registers s1 and s2 and parks it in a 2-entry queue, so
//    it takes the next pixel while the back end still iterates.
//  - The back end shares one 32x32 multiplier, with three fixed-point multiplies per
//    iteration; the iteration loop of the back end sets throughput.
//  - The result sits in an output register: a stalled rsp_ready holds it, while the
//    back end keeps working on the next queued pixel until it has its own result.
//  - Reset (synchronous, active high) empties the queue and pipeline and loads
//    default registers: 640 x 480, center 0, seed 0, step 2^-8, limit 256.
module mandelbrot_escape_iteration #(
   parameter int FRAC_BITS  = 52,
   parameter int ITER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_iterations,
   output logic        rsp_inside_res,
   output logic [62:0] rsp_magnitude_sq,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import mbe_pkg::*;

   logic [12:0] image_width_ff, image_height_ff;
   fix_type     center_re_ff, center_im_ff, seed_re_ff, seed_im_ff;
   logic [62:0] pixel_step_ff;
   logic [15:0] max_iter_ff;
   logic        csr_write;

   logic      q_has_room, q_not_empty, q_pop, push_valid;
   coord_type push_data, q_head;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 13'd640;
         image_height_ff <= 13'd480;
         center_re_ff    <= '0;
         center_im_ff    <= '0;
         seed_re_ff      <= '0;
         seed_im_ff      <= '0;
         pixel_step_ff   <= 63'd17592186044416;
         max_iter_ff     <= 16'd256;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_data[12:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_data[12:0];
            REG_CENTER_RE:    center_re_ff    <= csr_data;
            REG_CENTER_IM:    center_im_ff    <= csr_data;
            REG_SEED_RE:      seed_re_ff      <= csr_data;
            REG_SEED_IM:      seed_im_ff      <= csr_data;
            REG_PIXEL_STEP:   pixel_step_ff   <= csr_data[62:0];
            REG_MAX_ITER:     max_iter_ff     <= csr_data[15:0];
            default:          ;
         endcase
      end
   end

   mbe_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_column   (req_column),
      .req_row      (req_row),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .center_re    (center_re_ff),
      .center_im    (center_im_ff),
      .pixel_step   (pixel_step_ff),
      .q_has_room   (q_has_room),
      .push_valid   (push_valid),
      .push_data    (push_data)
   );

   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .has_room   (q_has_room),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   mbe_back #(
      .FRAC_BITS  (FRAC_BITS),
      .ITER_WIDTH (ITER_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .seed_re          (seed_re_ff),
      .seed_im          (seed_im_ff),
      .max_iterations   (max_iter_ff),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_iterations   (rsp_iterations),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_magnitude_sq (rsp_magnitude_sq)
   );

endmodule

// ===== bench/mbe_checker.sv =====
// Scoreboard for the escape-time pixel engine: mirrors the CSRs, predicts each
// pixel's beat and compares it with the rsp_ channel. Depends on mbe_pkg.
`timescale 1ns / 1ps
module mbe_checker #(
   parameter int FRAC_BITS = 52
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_iterations,
   input  logic        rsp_inside_res,
   input  logic [62:0] rsp_magnitude_sq,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output int          mismatch_count,
   output int          pixels_owed
);
   import mbe_pkg::*;

   typedef struct {
      logic [15:0] iterations;
      logic        inside_res;
      logic [62:0] magnitude_sq;
   } pixel_result_type;

   pixel_result_type owed_q[$];

   logic [12:0] width_q, height_q;
   fix_type     cen_re_q, cen_im_q, seed_re_q, seed_im_q;
   logic [62:0] step_q;
   logic [15:0] limit_q;

   localparam logic [63:0] BAIL_FIX = 64'(BAILOUT_INT) << FRAC_BITS;

   // sign a 128-bit magnitude and clamp to the 64-bit signed range
   function automatic fix_type clamp_signed(logic neg, logic [127:0] mag);
      if (neg)
         return (mag[127:63] != 0) ? FIX_MIN : fix_type'(-mag[63:0]);
      return (mag[127:63] != 0) ? FIX_MAX : fix_type'(mag[63:0]);
   endfunction

   function automatic fix_type add_clamp(fix_type a, fix_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      return (s[64] != s[63]) ? (s[64] ? FIX_MIN : FIX_MAX) : s[63:0];
   endfunction

   function automatic fix_type sub_clamp(fix_type a, fix_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      return (s[64] != s[63]) ? (s[64] ? FIX_MIN : FIX_MAX) : s[63:0];
   endfunction

   function automatic fix_type fix_product(fix_type a, fix_type b);
      logic [63:0]  ma, mb;
      logic [127:0] p;
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
      p = {64'd0, ma} * {64'd0, mb};
      return clamp_signed(a[63] ^ b[63], p >> FRAC_BITS);
   endfunction

   function automatic fix_type pixel_coord(fix_type cen, logic [11:0] idx, logic [12:0] size);
      int           d;
      logic [127:0] p;
      d = int'(idx) - int'(size >> 1);
      p = 128'(d < 0 ? -d : d) * {65'd0, step_q};
      return add_clamp(cen, clamp_signed(d < 0, p));
   endfunction

   function automatic pixel_result_type escape_pixel(logic [11:0] col, logic [11:0] row);
      pixel_result_type r;
      fix_type     cx, cy, x, y, x2, y2, px, py, xy;
      logic [63:0] sum;
      int unsigned lim, n, phase;
      logic        over;
      lim = (limit_q == 0) ? 1 : limit_q;
      cx = pixel_coord(cen_re_q, col, width_q);
      cy = pixel_coord(cen_im_q, row, height_q);
      x = seed_re_q;
      y = seed_im_q;
      px = x;
      py = y;
      x2 = 0;
      y2 = 0;
      sum = 0;
      n = 1;
      phase = 1;
      over = 0;
      while (n < lim && !over) begin
         xy = fix_product(x, y);
         y = add_clamp(add_clamp(xy, xy), cy);
         x = add_clamp(sub_clamp(x2, y2), cx);
         x2 = fix_product(x, x);
         y2 = fix_product(y, y);
         sum = 64'(x2) + 64'(y2);
         over = (x2 == FIX_MAX) || (y2 == FIX_MAX) || (sum > BAIL_FIX);
         n++;
         phase++;
         if (phase >= CYCLE_PERIOD) begin
            phase = 0;
            if (px == x && py == y) begin
               n = lim;   // orbit repeats: call it inside
            end else begin
               px = x;
               py = y;
            end
         end
      end
      r.iterations   = n[15:0];
      r.inside_res   = (n == lim);
      r.magnitude_sq = sum[63] ? {63{1'b1}} : sum[62:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         width_q   <= 13'd640;
         height_q  <= 13'd480;
         cen_re_q  <= '0;
         cen_im_q  <= '0;
         seed_re_q <= '0;
         seed_im_q <= '0;
         step_q    <= 63'd17592186044416;
         limit_q   <= 16'd256;
         owed_q.delete();
         mismatch_count <= 0;
         pixels_owed    <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_IMAGE_WIDTH:  width_q   <= csr_data[12:0];
               REG_IMAGE_HEIGHT: height_q  <= csr_data[12:0];
               REG_CENTER_RE:    cen_re_q  <= csr_data;
               REG_CENTER_IM:    cen_im_q  <= csr_data;
               REG_SEED_RE:      seed_re_q <= csr_data;
               REG_SEED_IM:      seed_im_q <= csr_data;
               REG_PIXEL_STEP:   step_q    <= csr_data[62:0];
               REG_MAX_ITER:     limit_q   <= csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            owed_q.push_back(escape_pixel(req_column, req_row));
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected beat iter=%0d inside=%0b mag=%h", $time,
                        rsp_iterations, rsp_inside_res, rsp_magnitude_sq);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = owed_q.pop_front();
               if (rsp_iterations !== want.iterations || rsp_inside_res !== want.inside_res ||
                   rsp_magnitude_sq !== want.magnitude_sq) begin
                  $display("%0t: expected iter=%0d inside=%0b mag=%h, got iter=%0d inside=%0b mag=%h",
                           $time, want.iterations, want.inside_res, want.magnitude_sq,
                           rsp_iterations, rsp_inside_res, rsp_magnitude_sq);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         pixels_owed <= owed_q.size();
      end
   end

endmodule

// ===== bench/tb_top.sv =====
// Top of the escape-time pixel engine bench: clock, reset, CSR phases, pixel
// stimulus and verdict. Depends on mbe_pkg, mbe_checker and the engine RTL.
`timescale 1ns / 1ps
module tb_top;
   import mbe_pkg::*;

   localparam logic [63:0] ONE_FIX    = 64'd1 << 52;
   localparam logic [63:0] PIX_256    = 64'd1 << 44;   // 1/256, the reset step
   localparam int          WATCHDOG   = 20000;
   localparam int          TARGET     = 1900;
   localparam int          CALM_AFTER = 1750;         // no idling past this count

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   logic [11:0] req_column = 0, req_row = 0;
   logic        rsp_valid, rsp_ready = 0;
   logic [15:0] rsp_iterations;
   logic        rsp_inside_res;
   logic [62:0] rsp_magnitude_sq;
   logic        csr_valid = 0, csr_ready;
   logic [2:0]  csr_index = 0;
   logic [63:0] csr_data = 0;

   int mismatch_count, pixels_owed;
   int sent = 0;
   logic calm = 0;        // turns off idling on both sides
   logic hold_rsp = 0;    // asks the receiver for one long hold-off
   int   quiet_cycles = 0;

   always #5 clock = ~clock;

   mandelbrot_escape_iteration i_dut (.*);

   mbe_checker i_checker (.*);

   // Watchdog: any accepted beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request.
   // The hold-off outlasts four of the longest window pixels, so req backs up.
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (4000) @(posedge clock);
            hold_rsp <= 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // one CSR beat; csr_valid drops for a cycle after
   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic load_view(logic [12:0] w, logic [12:0] h, logic [63:0] cre, logic [63:0] cim,
                            logic [63:0] sre, logic [63:0] sim, logic [62:0] step,
                            logic [15:0] lim);
      write_reg(REG_IMAGE_WIDTH, 64'(w));
      write_reg(REG_IMAGE_HEIGHT, 64'(h));
      write_reg(REG_CENTER_RE, cre);
      write_reg(REG_CENTER_IM, cim);
      write_reg(REG_SEED_RE, sre);
      write_reg(REG_SEED_IM, sim);
      write_reg(REG_PIXEL_STEP, 64'(step));
      write_reg(REG_MAX_ITER, 64'(lim));
   endtask

   // one pixel beat; valid stays up unless an idle burst follows
   task automatic send_pixel(logic [11:0] col, logic [11:0] row);
      req_valid  <= 1;
      req_column <= col;
      req_row    <= row;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      sent++;
      if (sent >= CALM_AFTER) calm <= 1;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // sender pause: every pixel back, plus a margin before CSR writes
   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pixels_owed != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [12:0] w, h;
      logic [62:0] step;
      logic [15:0] lim;
      int          batch, ph;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset view: c = 0 at the image middle, so the orbit check fires
      send_pixel(12'd320, 12'd240);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd330, 12'd250);
      drain();

      // full iteration limit; only fixed-point or fast-escaping pixels
      load_view(13'd1, 13'd1, 64'd0, 64'd0, 64'd0, 64'd0, PIX_256, 16'hFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      drain();

      // limit of one, then zero
      load_view(13'd4096, 13'd4096, rand64(), rand64(), rand64(), rand64(), 63'd1, 16'd1);
      send_pixel(12'd5, 12'd7);
      drain();
      write_reg(REG_MAX_ITER, 64'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      drain();

      // saturation everywhere: extreme center, seed and step, odd sizes
      load_view(13'h1FFF, 13'd0, {1'b0, {63{1'b1}}}, {1'b1, 63'd0}, {1'b1, 63'd0},
                {1'b0, {63{1'b1}}}, {63{1'b1}}, 16'd5);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd0, 12'd4095);
      drain();

      // escape on the last allowed step still reports inside
      load_view(13'd2, 13'd2, 64'd0, 64'd0, 64'd0, 64'd0, 63'(ONE_FIX * 4), 16'd2);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd0, 12'd0);
      drain();
      write_reg(REG_MAX_ITER, 64'd3);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd0);
      drain();

      // random views: mostly a window on the set, sometimes anything at all
      ph = 0;
      while (sent < TARGET) begin
         if ($urandom_range(0, 6) != 0) begin
            w    = 13'($urandom_range(1, 64));
            h    = 13'($urandom_range(1, 64));
            step = 63'(PIX_256 << $urandom_range(0, 6));
            lim  = 16'($urandom_range(1, 32));
            load_view(w, h, 64'(longint'($urandom_range(0, 640)) - 512) << 44,
                      64'(longint'($urandom_range(0, 512)) - 256) << 44,
                      ($urandom_range(0, 3) == 0) ? rand64() >>> 10 : 64'd0,
                      ($urandom_range(0, 3) == 0) ? rand64() >>> 10 : 64'd0, step, lim);
         end else begin
            w    = 13'($urandom_range(0, 8191));
            h    = 13'($urandom_range(0, 8191));
            step = 63'(rand64() >> $urandom_range(1, 63));
            lim  = 16'($urandom_range(0, 12));
            load_view(w, h, rand64(), rand64(), rand64(), rand64(), step, lim);
         end
         batch = $urandom_range(20, 60);
         for (int k = 0; k < batch && sent < TARGET; k++) begin
            if (ph == 3 && k == 2) hold_rsp <= 1;   // long stall: queue fills, req backs up
            if ($urandom_range(0, 4) == 0 || w < 2 || h < 2)
               send_pixel(12'($urandom), 12'($urandom));
            else
               send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)));
         end
         drain();
         ph++;
      end

      drain();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/mbe_pkg.sv
hw/rtl/mbe_queue.sv
hw/rtl/mbe_front.sv
hw/rtl/mbe_mul.sv
hw/rtl/mbe_back.sv
hw/rtl/mandelbrot_escape_iteration.sv
bench/mbe_checker.sv
bench/tb_top.sv
